// ===== design/xor_checksum_frame_receiver_top_assert.svh =====
// Assertion macros used by the frame receiver top design file.
`ifndef XOR_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define XOR_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define XCFR_ASSERT(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("frame receiver assertion failed");
// Condition that must never be true outside reset.
`define XCFR_ASSERT_NEVER(label, clk_sig, rstn_sig, cond) \
    `XCFR_ASSERT(label, clk_sig, rstn_sig, !(cond))
`else
`define XCFR_ASSERT(label, clk_sig, rstn_sig, prop)
`define XCFR_ASSERT_NEVER(label, clk_sig, rstn_sig, cond)
`endif
`endif

// ===== design/xcfr_pkg.sv =====
// Types and constants for the XOR checksum frame receiver.
package xcfr_pkg;

    localparam logic [7:0] HDR0 = 8'hAA;
    localparam logic [7:0] HDR1 = 8'h55;
    localparam logic [7:0] KEEP_LIMIT_RESET = 8'hFF;
    localparam int unsigned TDATA_W = 24;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    typedef struct packed {
        logic       is_frame_end;
        logic [7:0] payload_index;
        logic [7:0] payload_value;
        logic       checksum_bad;
    } result_t;

endpackage

// ===== design/xor_checksum_frame_receiver_top.sv =====
// Each result is registered in the result register, or in the skid register
// when that is full and not draining. One byte per cycle while skid is empty.
// A two-entry output stage (result register plus skid register) keeps the
// slave side ready while one result waits for the consumer.
// Reset (rst_n low, asynchronous) returns to header hunting, clears the
// checksum state and the output stage, and sets keep_limit to 255.
`include "xor_checksum_frame_receiver_top_assert.svh"

module xor_checksum_frame_receiver_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] payload_index, [15:8] payload_value, [16] checksum_bad, [23:17] zero
    output logic [xcfr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser,   // [0] is_frame_end
    input  logic                        cfg_wr_en,
    input  logic [7:0]                  cfg_wr_data     // keep_limit
);

    xcfr_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        length_reg, length_next;
    logic [7:0]        position_reg, position_next;
    logic [7:0]        keep_limit_reg;
    logic [7:0]        position_inc;

    xcfr_pkg::result_t res_next;
    logic              res_fire;
    logic              in_fire;

    xcfr_pkg::result_t main_reg;
    xcfr_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;

    logic              in_data_phase;
    logic              check_fire;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign position_inc  = position_reg + 8'd1;
    assign in_data_phase = (phase_reg == xcfr_pkg::PH_DATA);
    assign check_fire    = in_fire && (phase_reg == xcfr_pkg::PH_CHECK);

    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        length_next   = length_reg;
        position_next = position_reg;
        res_fire      = 1'b0;
        res_next      = '0;
        case (phase_reg)
            xcfr_pkg::PH_HUNT1:
            begin
                phase_next = (s_axis_tdata == xcfr_pkg::HDR1) ? xcfr_pkg::PH_LEN
                                                              : xcfr_pkg::PH_HUNT0;
            end
            xcfr_pkg::PH_LEN:
            begin
                length_next   = s_axis_tdata;
                xor_next      = s_axis_tdata;
                position_next = 8'd0;
                phase_next    = (s_axis_tdata == 8'd0) ? xcfr_pkg::PH_CHECK
                                                       : xcfr_pkg::PH_DATA;
            end
            xcfr_pkg::PH_DATA:
            begin
                xor_next      = xor_reg ^ s_axis_tdata;
                position_next = position_inc;
                if (position_inc >= length_reg)
                begin
                    phase_next = xcfr_pkg::PH_CHECK;
                end
                if (position_reg < keep_limit_reg)
                begin
                    res_fire               = 1'b1;
                    res_next.payload_index = position_reg;
                    res_next.payload_value = s_axis_tdata;
                end
            end
            xcfr_pkg::PH_CHECK:
            begin
                res_fire              = 1'b1;
                res_next.is_frame_end = 1'b1;
                res_next.checksum_bad = (xor_reg != s_axis_tdata);
                phase_next            = xcfr_pkg::PH_HUNT0;
            end
            default:
            begin
                phase_next = (s_axis_tdata == xcfr_pkg::HDR0) ? xcfr_pkg::PH_HUNT1
                                                              : xcfr_pkg::PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= xcfr_pkg::PH_HUNT0;
            xor_reg      <= 8'd0;
            length_reg   <= 8'd0;
            position_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            length_reg   <= length_next;
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= xcfr_pkg::KEEP_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            keep_limit_reg <= cfg_wr_data;
        end
    end

    // Output stage: a new result goes to the skid register only when the result
    // register is full and not draining in this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_valid_reg && m_axis_tready && skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire && res_fire)
            begin
                if (main_valid_reg && !m_axis_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    main_valid_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_valid_reg && m_axis_tready && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (in_fire && res_fire)
        begin
            if (main_valid_reg && !m_axis_tready)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                main_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tuser  = main_reg.is_frame_end;
    assign m_axis_tdata  = {7'd0, main_reg.checksum_bad, main_reg.payload_value,
                            main_reg.payload_index};

    `XCFR_ASSERT_NEVER(a_skid_without_main, clk, rst_n, skid_valid_reg && !main_valid_reg)
    `XCFR_ASSERT_NEVER(a_data_zero_length, clk, rst_n, in_data_phase && (length_reg == 8'd0))
    `XCFR_ASSERT_NEVER(a_data_position, clk, rst_n, in_data_phase && (position_reg >= length_reg))
    `XCFR_ASSERT(a_check_emits, clk, rst_n, check_fire |=> m_axis_tvalid)

endmodule
